/* design/holonomic_inverse_kinematics_top_defines.svh */
// Assertion helpers for the kinematics block checker.
`ifndef HOLONOMIC_INVERSE_KINEMATICS_TOP_DEFINES_SVH
`define HOLONOMIC_INVERSE_KINEMATICS_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define HIK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define HIK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hik_pkg.sv */
package hik_pkg;

    localparam int NUM_STAGES = 6;
    localparam int ANGLE_IN_W = 16;
    localparam int VEL_W      = 16;
    localparam int WHEEL_W    = 18;
    localparam int TURRET_W   = 17;
    localparam int SINCOS_W   = 17;   // signed, covers +/-32768
    localparam int MIX_W      = 18;   // c+s, c-s

    localparam logic [1:0] REG_VEL_X    = 2'd0;
    localparam logic [1:0] REG_VEL_Y    = 2'd1;
    localparam logic [1:0] REG_ROT_RATE = 2'd2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q16 gains: 180/(pi*0.1352065) and 180/pi
    localparam logic signed [25:0] K1_Q16 = 26'sd27771862;
    localparam logic signed [22:0] K2_Q16 = 23'sd3754936;

    localparam logic signed [35:0] WHEEL_HALF  = 36'sd16384;
    localparam logic signed [60:0] TURRET_HALF = 61'sd1 <<< 40;

    localparam logic signed [WHEEL_W-1:0]  WHEEL_MAX  = 18'sh1FFFF;
    localparam logic signed [WHEEL_W-1:0]  WHEEL_MIN  = 18'sh20000;
    localparam logic signed [TURRET_W-1:0] TURRET_MAX = 17'shFFFF;
    localparam logic signed [TURRET_W-1:0] TURRET_MIN = 17'sh10000;

    typedef logic [NUM_STAGES:1] stage_vec_t;

    typedef struct packed {
        logic [SINCOS_W-1:0] s;
        logic [SINCOS_W-1:0] c;
        logic [MIX_W-1:0]    u;   // c - s
        logic [MIX_W-1:0]    v;   // c + s
    } trig_t;

    function automatic logic signed [WHEEL_W-1:0] sat_wheel(input logic signed [20:0] val);
        logic signed [WHEEL_W-1:0] res;
        if (val > 21'(WHEEL_MAX))
            res = WHEEL_MAX;
        else if (val < 21'(WHEEL_MIN))
            res = WHEEL_MIN;
        else
            res = val[WHEEL_W-1:0];
        return res;
    endfunction

    function automatic logic signed [TURRET_W-1:0] sat_turret(input logic signed [19:0] val);
        logic signed [TURRET_W-1:0] res;
        if (val > 20'(TURRET_MAX))
            res = TURRET_MAX;
        else if (val < 20'(TURRET_MIN))
            res = TURRET_MIN;
        else
            res = val[TURRET_W-1:0];
        return res;
    endfunction

endpackage

/* design/hik_trig.sv */
module hik_trig
    import hik_pkg::*;
#(
    parameter int ANGLE_BITS           = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
)
(
    input  logic                  clk,
    input  stage_vec_t            en,
    input  logic [ANGLE_IN_W-1:0] drive_angle,
    output trig_t                 trig
);

    localparam int SAB    = SINE_TABLE_ADDR_BITS;
    localparam int QTR    = 1 << SAB;
    localparam int PW     = SAB + 2;
    localparam int AW     = SAB + 1;
    localparam int SH     = ANGLE_BITS - PW;
    localparam int EXT_W  = (ANGLE_BITS > ANGLE_IN_W) ? ANGLE_BITS : ANGLE_IN_W;

    // Quarter-wave sine entry, Q1.15 unsigned, by Taylor series in Q30
    function automatic logic [15:0] sine_entry(input int i);
        logic [63:0] xa;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        xa   = (HALF_PI_Q30 * 64'(i)) >> SAB;
        x2   = (xa * xa) >> 30;
        term = xa;
        sum  = xa;
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return 16'((sum + 64'd16384) >> 15);
    endfunction

    logic [15:0] sine_rom [0:QTR];

    generate
        for (genvar g = 0; g <= QTR; g++)
        begin : g_rom
            assign sine_rom[g] = sine_entry(g);
        end
    endgenerate

    logic [EXT_W-1:0] angle_ext;
    logic [PW-1:0]    phase;
    logic [1:0]       quad_s;
    logic [1:0]       quad_c;
    logic [SAB-1:0]   idx;
    logic [AW-1:0]    addr_s;
    logic [AW-1:0]    addr_c;

    assign angle_ext = EXT_W'(drive_angle);

    generate
        if (SH >= 0)
        begin : g_trunc
            assign phase = angle_ext[ANGLE_BITS-1:SH];
        end
        else
        begin : g_widen
            assign phase = {angle_ext[ANGLE_BITS-1:0], {(-SH){1'b0}}};
        end
    endgenerate

    assign quad_s = phase[PW-1:PW-2];
    assign quad_c = quad_s + 2'd1;    // cos = sin a quarter turn ahead
    assign idx    = phase[SAB-1:0];
    assign addr_s = quad_s[0] ? AW'(QTR) - AW'(idx) : AW'(idx);
    assign addr_c = quad_c[0] ? AW'(QTR) - AW'(idx) : AW'(idx);

    logic [15:0] mag_s_reg;
    logic [15:0] mag_c_reg;
    logic        neg_s_reg;
    logic        neg_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag_s_reg <= sine_rom[addr_s];
            mag_c_reg <= sine_rom[addr_c];
            neg_s_reg <= quad_s[1];
            neg_c_reg <= quad_c[1];
        end
    end

    logic signed [SINCOS_W-1:0] s_next;
    logic signed [SINCOS_W-1:0] c_next;
    trig_t                      trig_next;
    trig_t                      trig_reg;

    always_comb
    begin
        s_next      = neg_s_reg ? -$signed({1'b0, mag_s_reg}) : $signed({1'b0, mag_s_reg});
        c_next      = neg_c_reg ? -$signed({1'b0, mag_c_reg}) : $signed({1'b0, mag_c_reg});
        trig_next.s = s_next;
        trig_next.c = c_next;
        trig_next.u = MIX_W'(c_next) - MIX_W'(s_next);
        trig_next.v = MIX_W'(c_next) + MIX_W'(s_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

/* design/hik_mix.sv */
module hik_mix
    import hik_pkg::*;
(
    input  logic                       clk,
    input  stage_vec_t                 en,
    input  trig_t                      trig,
    input  logic signed [VEL_W-1:0]    vel_x,
    input  logic signed [VEL_W-1:0]    vel_y,
    input  logic signed [VEL_W-1:0]    rot_rate,
    output logic signed [WHEEL_W-1:0]  wheel_one,
    output logic signed [WHEEL_W-1:0]  wheel_two,
    output logic signed [TURRET_W-1:0] turret
);

    logic signed [SINCOS_W-1:0] s_in;
    logic signed [SINCOS_W-1:0] c_in;
    logic signed [MIX_W-1:0]    u_in;
    logic signed [MIX_W-1:0]    v_in;

    assign s_in = $signed(trig.s);
    assign c_in = $signed(trig.c);
    assign u_in = $signed(trig.u);
    assign v_in = $signed(trig.v);

    // stage 3: products, Q27
    logic signed [33:0] pxu_reg;
    logic signed [33:0] pyv_reg;
    logic signed [33:0] pxv_reg;
    logic signed [33:0] pyu_reg;
    logic signed [32:0] pxc_reg;
    logic signed [32:0] pys_reg;
    logic signed [38:0] prk_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pxu_reg <= 34'(vel_x) * 34'(u_in);
            pyv_reg <= 34'(vel_y) * 34'(v_in);
            pxv_reg <= 34'(vel_x) * 34'(v_in);
            pyu_reg <= 34'(vel_y) * 34'(u_in);
            pxc_reg <= 33'(vel_x) * 33'(c_in);
            pys_reg <= 33'(vel_y) * 33'(s_in);
            prk_reg <= 39'(rot_rate) * 39'(K2_Q16);
        end
    end

    // stage 4: sums
    logic signed [34:0] m1_reg;
    logic signed [34:0] m2_reg;
    logic signed [33:0] lin_reg;
    logic signed [38:0] rk4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            m1_reg  <= -(35'(pxu_reg) + 35'(pyv_reg));
            m2_reg  <= 35'(pyu_reg) - 35'(pxv_reg);
            lin_reg <= -(34'(pxc_reg) + 34'(pys_reg));
            rk4_reg <= prk_reg;
        end
    end

    // stage 5: turret gain multiply, wheel rounding
    logic signed [59:0]        lk_reg;
    logic signed [38:0]        rk5_reg;
    logic signed [WHEEL_W-1:0] w1_reg;
    logic signed [WHEEL_W-1:0] w2_reg;
    logic signed [35:0]        m1_rnd;
    logic signed [35:0]        m2_rnd;

    assign m1_rnd = (36'(m1_reg) + WHEEL_HALF) >>> 15;
    assign m2_rnd = (36'(m2_reg) + WHEEL_HALF) >>> 15;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            lk_reg  <= 60'(lin_reg) * 60'(K1_Q16);
            rk5_reg <= rk4_reg;
            w1_reg  <= sat_wheel(m1_rnd[20:0]);
            w2_reg  <= sat_wheel(m2_rnd[20:0]);
        end
    end

    // stage 6: output register; turret sum is Q43
    logic signed [60:0]         tsum;
    logic signed [60:0]         trnd;
    logic signed [WHEEL_W-1:0]  wheel_one_reg;
    logic signed [WHEEL_W-1:0]  wheel_two_reg;
    logic signed [TURRET_W-1:0] turret_reg;

    assign tsum = 61'(lk_reg) + (61'(rk5_reg) <<< 15) + TURRET_HALF;
    assign trnd = tsum >>> 41;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            wheel_one_reg <= w1_reg;
            wheel_two_reg <= w2_reg;
            turret_reg    <= sat_turret(trnd[19:0]);
        end
    end

    assign wheel_one = wheel_one_reg;
    assign wheel_two = wheel_two_reg;
    assign turret    = turret_reg;

endmodule

/* design/holonomic_inverse_kinematics_top.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// input     | in_valid / in_ready    | drive_angle
// output    | out_valid / out_ready  | wheel_one_vel, wheel_two_vel, turret_rate
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transfer per cycle sustained while out_ready stays high; each stage below is registered.
// Stages: sine ROM read, sign/sum, products, sums, turret gain multiply, output.
// Reset clears stage valid bits and the three setpoint registers to zero.
// A stall at the output fills empty stages first; in_ready drops only when
// every stage holds an item. cfg_ready is always high.
module holonomic_inverse_kinematics_top
    import hik_pkg::*;
#(
    parameter int ANGLE_BITS           = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ANGLE_IN_W-1:0]      drive_angle,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [WHEEL_W-1:0]  wheel_one_vel,
    output logic signed [WHEEL_W-1:0]  wheel_two_vel,
    output logic signed [TURRET_W-1:0] turret_rate,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [VEL_W-1:0]           cfg_data
);

    logic signed [VEL_W-1:0] vel_x_reg;
    logic signed [VEL_W-1:0] vel_y_reg;
    logic signed [VEL_W-1:0] rot_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            rot_rate_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VEL_X:    vel_x_reg    <= $signed(cfg_data);
                REG_VEL_Y:    vel_y_reg    <= $signed(cfg_data);
                REG_ROT_RATE: rot_rate_reg <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t en;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[NUM_STAGES] = !valid_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
            en[k] = !valid_reg[k] || en[k + 1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[1])
            valid_next[1] = in_valid;
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[1];
    assign out_valid = valid_reg[NUM_STAGES];

    trig_t trig;

    hik_trig #(
        .ANGLE_BITS           (ANGLE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_trig (
        .clk         (clk),
        .en          (en),
        .drive_angle (drive_angle),
        .trig        (trig)
    );

    hik_mix u_mix (
        .clk       (clk),
        .en        (en),
        .trig      (trig),
        .vel_x     (vel_x_reg),
        .vel_y     (vel_y_reg),
        .rot_rate  (rot_rate_reg),
        .wheel_one (wheel_one_vel),
        .wheel_two (wheel_two_vel),
        .turret    (turret_rate)
    );

endmodule

/* design/hik_checker.sv */
`include "holonomic_inverse_kinematics_top_defines.svh"

module hik_checker
    import hik_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [WHEEL_W-1:0]  wheel_one_vel,
    input logic signed [WHEEL_W-1:0]  wheel_two_vel,
    input logic signed [TURRET_W-1:0] turret_rate
);

    logic       in_xfer;
    logic       out_xfer;
    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 4'd1;
        else if (out_xfer && !in_xfer)
            inflight_next = inflight_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    `HIK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable({wheel_one_vel, wheel_two_vel, turret_rate}), "output dropped while stalled")
    `HIK_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, inflight_reg != 4'd0, "result without a pending input")
    `HIK_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, inflight_reg <= 4'(NUM_STAGES), "more items in flight than stages")
    `HIK_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output register")

endmodule

bind holonomic_inverse_kinematics_top hik_checker u_hik_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wheel_one_vel (wheel_one_vel),
    .wheel_two_vel (wheel_two_vel),
    .turret_rate   (turret_rate)
);

/* dv/tb_holonomic_inverse_kinematics_top.sv */
`timescale 1ns / 100ps

module tb_holonomic_inverse_kinematics_top
    import hik_pkg::*;
();

    localparam int QTR_STEPS    = 1024;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 4;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 210;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Q16 gains: 180/(pi*0.1352065) and 180/pi
    localparam longint TURRET_GAIN_LIN = 64'sd27771862;
    localparam longint TURRET_GAIN_ROT = 64'sd3754936;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [WHEEL_W-1:0]  wheel_one;
        logic signed [WHEEL_W-1:0]  wheel_two;
        logic signed [TURRET_W-1:0] turret;
    } wheel_cmd_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [ANGLE_IN_W-1:0]      drive_angle;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [WHEEL_W-1:0]  wheel_one_vel;
    logic signed [WHEEL_W-1:0]  wheel_two_vel;
    logic signed [TURRET_W-1:0] turret_rate;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index;
    logic [VEL_W-1:0]           cfg_data;

    int          sine_tab [0:QTR_STEPS];
    wheel_cmd_t  expected_cmds [$];
    wheel_cmd_t  want_cmd;
    int          mismatches;
    int          cycle_count;
    bit          in_gaps;
    bit          out_stalls;

    logic signed [VEL_W-1:0] set_vel_x;
    logic signed [VEL_W-1:0] set_vel_y;
    logic signed [VEL_W-1:0] set_rot_rate;

    holonomic_inverse_kinematics_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .drive_angle   (drive_angle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .wheel_one_vel (wheel_one_vel),
        .wheel_two_vel (wheel_two_vel),
        .turret_rate   (turret_rate),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Quarter-wave sine in Q1.15, Taylor series evaluated in Q30
    function automatic void build_sine_table();
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned acc;
        for (int i = 0; i <= QTR_STEPS; i++)
        begin
            ang  = (QUARTER_TURN_Q30 * longint'(i)) >> 10;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = ang;
            for (int k = 1; k <= 9; k++)
            begin
                term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            sine_tab[i] = int'((acc + 64'd16384) >> 15);
        end
    endfunction

    // p: 12-bit phase, quadrant in the top two bits
    function automatic longint sine_of_phase(input logic [11:0] p);
        longint mag;
        mag = p[10] ? sine_tab[QTR_STEPS - int'(p[9:0])] : sine_tab[p[9:0]];
        return p[11] ? -mag : mag;
    endfunction

    // nearest, ties toward +inf
    function automatic longint round_half_up(input longint val, input int n);
        return (val + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_signed(input longint val, input int width);
        longint hi;
        hi = (64'sd1 <<< (width - 1)) - 1;
        if (val > hi)
            return hi;
        if (val < -hi - 1)
            return -hi - 1;
        return val;
    endfunction

    function automatic wheel_cmd_t predict_wheel_cmd(input logic [ANGLE_IN_W-1:0] angle);
        logic [11:0] phase;
        longint s, c, x, y, r, u, v, m1, m2, lin, tq;
        wheel_cmd_t res;
        phase = angle[15:4];  // finer bits below the table resolution are dropped
        s = sine_of_phase(phase);
        c = sine_of_phase(phase + 12'd1024);
        x = set_vel_x;
        y = set_vel_y;
        r = set_rot_rate;
        u = c - s;
        v = c + s;
        m1 = -(x * u + y * v);
        m2 = -(x * v) + y * u;
        lin = -(x * c + y * s);
        tq = lin * TURRET_GAIN_LIN + r * TURRET_GAIN_ROT * 64'sd32768;
        res.wheel_one = WHEEL_W'(clamp_signed(round_half_up(m1, 15), WHEEL_W));
        res.wheel_two = WHEEL_W'(clamp_signed(round_half_up(m2, 15), WHEEL_W));
        res.turret    = TURRET_W'(clamp_signed(round_half_up(tq, 41), TURRET_W));
        return res;
    endfunction

    // mostly zero or short, now and then long
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ANGLE_IN_W-1:0] random_angle();
        logic [ANGLE_IN_W-1:0] base;
        if ($urandom_range(0, 3) != 0)
            return ANGLE_IN_W'($urandom);
        // land near a quadrant boundary
        base = ANGLE_IN_W'($urandom_range(0, 3)) << 14;
        return base + ANGLE_IN_W'($urandom_range(0, 63)) - 16'd32;
    endfunction

    function automatic logic [VEL_W-1:0] random_setpoint();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return VEL_W'($urandom);
        endcase
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                report("unexpected result wheel_one_vel", 0, wheel_one_vel);
            end
            else
            begin
                want_cmd = expected_cmds.pop_front();
                if (wheel_one_vel !== want_cmd.wheel_one)
                    report("wheel_one_vel", want_cmd.wheel_one, wheel_one_vel);
                if (wheel_two_vel !== want_cmd.wheel_two)
                    report("wheel_two_vel", want_cmd.wheel_two, wheel_two_vel);
                if (turret_rate !== want_cmd.turret)
                    report("turret_rate", want_cmd.turret, turret_rate);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output backpressure
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!out_stalls)
            begin
                out_ready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                hold = random_gap();
            end
            else
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    task automatic send_angle(input logic [ANGLE_IN_W-1:0] angle);
        int gap;
        gap = in_gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        drive_angle <= angle;
        do @(posedge clk); while (!in_ready);
        expected_cmds.push_back(predict_wheel_cmd(angle));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called with the pipeline drained
    task automatic write_setpoint(input logic [1:0] idx, input logic [VEL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_VEL_X:    set_vel_x    = data;
            REG_VEL_Y:    set_vel_y    = data;
            REG_ROT_RATE: set_rot_rate = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_setpoints();
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        send_angle(16'h0000);
        send_angle(16'hFFFF);
        wait_for_results();
    endtask

    task automatic test_angle_corners();
        logic [ANGLE_IN_W-1:0] corners [13];
        corners = '{16'h0000, 16'h000F, 16'h0010, 16'h3FF0, 16'h4000, 16'h4008,
                    16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hE000, 16'h2000,
                    16'hFFFF};
        write_setpoint(REG_VEL_X, 16'h7FFF);
        write_setpoint(REG_VEL_Y, 16'h8000);
        write_setpoint(REG_ROT_RATE, 16'h8000);
        foreach (corners[i])
            send_angle(corners[i]);
        wait_for_results();
    endtask

    task automatic test_register_writes();
        // unused index must leave all setpoints alone
        write_setpoint(REG_UNUSED, 16'h5A5A);
        send_angle(16'h1234);
        wait_for_results();
        write_setpoint(REG_VEL_X, 16'h8000);
        write_setpoint(REG_VEL_Y, 16'h8000);
        write_setpoint(REG_ROT_RATE, 16'h7FFF);
        send_angle(16'h2000);
        send_angle(16'h6000);
        wait_for_results();
        write_setpoint(REG_VEL_X, 16'h7FFF);
        write_setpoint(REG_VEL_Y, 16'h7FFF);
        send_angle(16'hA000);
        send_angle(16'hE000);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 0)
            begin
                write_setpoint(REG_VEL_X, 16'h7FFF);
                write_setpoint(REG_VEL_Y, 16'h7FFF);
                write_setpoint(REG_ROT_RATE, 16'h7FFF);
            end
            else if (seg == 1)
            begin
                write_setpoint(REG_VEL_X, 16'h8000);
                write_setpoint(REG_VEL_Y, 16'h8000);
                write_setpoint(REG_ROT_RATE, 16'h8000);
            end
            else
            begin
                write_setpoint(REG_VEL_X, random_setpoint());
                if ($urandom_range(0, 2) != 0)
                    write_setpoint(REG_VEL_Y, random_setpoint());
                if ($urandom_range(0, 2) != 0)
                    write_setpoint(REG_ROT_RATE, random_setpoint());
                if ($urandom_range(0, 3) == 0)
                    write_setpoint(REG_UNUSED, VEL_W'($urandom));
            end
            // every fourth segment with a free-running pipe, the rest with idling enabled at random
            in_gaps    = (seg % 4 == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            out_stalls = (seg % 4 == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if (seg == 2 && n == SEG_ITEMS / 2)
                    wait_for_results();
                send_angle(random_angle());
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        build_sine_table();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        drive_angle  = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        set_vel_x    = '0;
        set_vel_y    = '0;
        set_rot_rate = '0;
        mismatches   = 0;
        cycle_count  = 0;
        in_gaps      = 1'b0;
        out_stalls   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_setpoints();
        test_angle_corners();
        test_register_writes();
        test_random_traffic();
        wait_for_results();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
